// ===== rtl/core/vss_pkg.sv =====
// shared types, widths and codes for the voxel sdf stamp pipeline
// no dependencies; imported by every module under rtl/core
package vss_pkg;

    // grid and fixed point format
    localparam int GRID_SIZE  = 64;
    localparam int COORD_W    = $clog2(GRID_SIZE);
    localparam int FRAC_W     = 8;
    localparam int PX_W       = COORD_W + FRAC_W;

    // field widths
    localparam int CENTER_W   = 17;
    localparam int EXTENT_W   = 16;
    localparam int DIST_W     = 24;
    localparam int COLOR_W    = 24;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // datapath widths, sized for grids up to 256 per axis
    localparam int AXES       = 3;
    localparam int DIFF_W     = 18;
    localparam int TERM_W     = 17;
    localparam int SQ_W       = 2 * TERM_W;
    localparam int RAD_W      = 36;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int REM_W      = ROOT_W + 1;
    localparam int BIAS_W     = 17;
    localparam int S_W        = 20;

    // paint thresholds in 8 fraction bit units
    localparam logic signed [S_W-1:0] SPHERE_PAINT_LIMIT = 20'sd384;
    localparam logic signed [S_W-1:0] BOX_PAINT_LIMIT    = 20'sd25;

    // operation codes: shape * 3 + merge rule
    typedef enum logic [OP_W-1:0] {
        OP_SPHERE_REPLACE,
        OP_SPHERE_UNION,
        OP_SPHERE_SUBTRACT,
        OP_BOX_REPLACE,
        OP_BOX_UNION,
        OP_BOX_SUBTRACT
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPERATION,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_EXTENT_X,
        REG_EXTENT_Y,
        REG_EXTENT_Z,
        REG_PAINT_COLOR
    } cfg_reg_t;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic signed [CENTER_W-1:0] center_z;
        logic [EXTENT_W-1:0]        extent_x;
        logic [EXTENT_W-1:0]        extent_y;
        logic [EXTENT_W-1:0]        extent_z;
        logic [COLOR_W-1:0]         paint_color;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]       voxel_x;
        logic [COORD_W-1:0]       voxel_y;
        logic [COORD_W-1:0]       voxel_z;
        logic signed [DIST_W-1:0] old_distance;
        logic [COLOR_W-1:0]       old_color;
    } voxel_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] new_distance;
        logic [COLOR_W-1:0]       new_color;
        logic                     painted;
    } result_t;

    // per voxel data riding alongside the distance math
    typedef struct packed {
        logic signed [DIST_W-1:0] old_distance;
        logic [COLOR_W-1:0]       old_color;
        logic signed [BIAS_W-1:0] bias;
    } side_t;

    // word handed from one square root cell to the next
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        side_t             side;
    } lane_t;

    function automatic logic shape_is_box(input logic [OP_W-1:0] op);
        return (op == OP_BOX_REPLACE) || (op == OP_BOX_UNION) || (op == OP_BOX_SUBTRACT);
    endfunction

endpackage

// ===== rtl/core/vss_front.sv =====
// front pipeline: offsets from center, box folding, squares and their sum
// depends on vss_pkg; feeds the first square root cell
module vss_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  vss_pkg::voxel_t voxel,
    input  vss_pkg::cfg_t   cfg,
    output logic           out_valid,
    output vss_pkg::lane_t  lane
);
    import vss_pkg::*;

    logic [COORD_W-1:0]         coord  [AXES];
    logic signed [CENTER_W-1:0] center [AXES];
    logic [EXTENT_W-1:0]        extent [AXES];

    logic signed [DIFF_W-1:0] diff_c [AXES];
    logic signed [DIFF_W-1:0] abs_c  [AXES];
    logic [TERM_W-1:0]        mag_c  [AXES];
    logic signed [DIFF_W-1:0] q_c    [AXES];
    logic [TERM_W-1:0]        term_c [AXES];
    logic [SQ_W-1:0]          sq_c   [AXES];
    logic signed [DIFF_W-1:0] qmax_c;
    logic signed [BIAS_W-1:0] bias_c;
    logic                     box;
    logic [RAD_W-1:0]         rad_c;

    logic signed [DIFF_W-1:0] s1_diff_reg [AXES];
    logic [TERM_W-1:0]        s2_mag_reg  [AXES];
    logic signed [DIFF_W-1:0] s2_q_reg    [AXES];
    logic [TERM_W-1:0]        s3_term_reg [AXES];
    logic [SQ_W-1:0]          s4_sq_reg   [AXES];
    logic [RAD_W-1:0]         s5_rad_reg;
    side_t                    s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg;
    logic [4:0]               valid_reg;

    // per axis views of the input word and configuration
    assign coord[0]  = voxel.voxel_x;
    assign coord[1]  = voxel.voxel_y;
    assign coord[2]  = voxel.voxel_z;
    assign center[0] = cfg.center_x;
    assign center[1] = cfg.center_y;
    assign center[2] = cfg.center_z;
    assign extent[0] = cfg.extent_x;
    assign extent[1] = cfg.extent_y;
    assign extent[2] = cfg.extent_z;

    assign box = shape_is_box(cfg.operation);

    // offset from center, magnitude, and distance outside each box slab
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            diff_c[a] = $signed({{(DIFF_W-PX_W){1'b0}}, coord[a], {FRAC_W{1'b0}}})
                      - $signed({{(DIFF_W-CENTER_W){center[a][CENTER_W-1]}}, center[a]});
            abs_c[a]  = (s1_diff_reg[a] < 0) ? -s1_diff_reg[a] : s1_diff_reg[a];
            mag_c[a]  = abs_c[a][TERM_W-1:0];
            q_c[a]    = $signed({1'b0, mag_c[a]})
                      - $signed({{(DIFF_W-EXTENT_W){1'b0}}, extent[a]});
        end
    end

    // terms to square and the additive bias for each shape
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (box)
            begin
                term_c[a] = (s2_q_reg[a] < 0) ? '0 : s2_q_reg[a][TERM_W-1:0];
            end
            else
            begin
                term_c[a] = s2_mag_reg[a];
            end
            sq_c[a] = s3_term_reg[a] * s3_term_reg[a];
        end
        qmax_c = s2_q_reg[0];
        if (s2_q_reg[1] > qmax_c)
        begin
            qmax_c = s2_q_reg[1];
        end
        if (s2_q_reg[2] > qmax_c)
        begin
            qmax_c = s2_q_reg[2];
        end
        if (box)
        begin
            bias_c = (qmax_c < 0) ? qmax_c[BIAS_W-1:0] : '0;
        end
        else
        begin
            bias_c = -$signed({1'b0, cfg.extent_x});
        end
        rad_c = {{(RAD_W-SQ_W){1'b0}}, s4_sq_reg[0]}
              + {{(RAD_W-SQ_W){1'b0}}, s4_sq_reg[1]}
              + {{(RAD_W-SQ_W){1'b0}}, s4_sq_reg[2]};
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                s1_diff_reg[a] <= diff_c[a];
                s2_mag_reg[a]  <= mag_c[a];
                s2_q_reg[a]    <= q_c[a];
                s3_term_reg[a] <= term_c[a];
                s4_sq_reg[a]   <= sq_c[a];
            end
            s1_side_reg.old_distance <= voxel.old_distance;
            s1_side_reg.old_color    <= voxel.old_color;
            s1_side_reg.bias         <= '0;
            s2_side_reg              <= s1_side_reg;
            s3_side_reg.old_distance <= s2_side_reg.old_distance;
            s3_side_reg.old_color    <= s2_side_reg.old_color;
            s3_side_reg.bias         <= bias_c;
            s4_side_reg              <= s3_side_reg;
            s5_side_reg              <= s4_side_reg;
            s5_rad_reg               <= rad_c;
        end
    end

    // stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    assign out_valid = valid_reg[4];
    assign lane.rad  = s5_rad_reg;
    assign lane.root = '0;
    assign lane.rem  = '0;
    assign lane.side = s5_side_reg;

endmodule

// ===== rtl/core/vss_root_cell.sv =====
// one square root cell: settles one root bit and passes the word on
// depends on vss_pkg; chained ROOT_STEPS times in the top level
module vss_root_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  vss_pkg::lane_t lane_in,
    output logic          out_valid,
    output vss_pkg::lane_t lane_out
);
    import vss_pkg::*;

    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             take;
    lane_t            lane_next;
    lane_t            lane_reg;
    logic             valid_reg;

    // bring down the next two radicand bits and try the next root bit
    always_comb
    begin
        cur   = {lane_in.rem, lane_in.rad[RAD_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W){1'b0}}, lane_in.root, 2'b01};
        diff  = cur - trial;
        take  = (cur >= trial);
        lane_next.rad  = lane_in.rad << 2;
        lane_next.root = {lane_in.root[ROOT_W-2:0], take};
        lane_next.rem  = take ? diff[REM_W-1:0] : cur[REM_W-1:0];
        lane_next.side = lane_in.side;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign lane_out  = lane_reg;

endmodule

// ===== rtl/core/vss_finish.sv =====
// rounding, shape distance, merge rule, paint test and output register
// depends on vss_pkg; takes the last square root cell's word
module vss_finish (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  vss_pkg::lane_t    lane,
    input  vss_pkg::cfg_t     cfg,
    output logic             out_valid,
    output vss_pkg::result_t  result
);
    import vss_pkg::*;

    logic                     round_up;
    logic [ROOT_W:0]          rounded;
    logic signed [S_W-1:0]    s_c;
    logic signed [S_W-1:0]    s_reg;
    side_t                    side_reg;
    logic                     s_valid_reg;

    logic signed [DIST_W-1:0] s_wide;
    logic signed [DIST_W-1:0] neg_s;
    logic signed [DIST_W-1:0] old_d;
    logic signed [S_W-1:0]    limit;
    logic                     paint;
    result_t                  result_next;
    result_t                  result_reg;
    logic                     result_valid_reg;

    // round the root to nearest, then add the shape bias
    always_comb
    begin
        round_up = (lane.rem > {1'b0, lane.root});
        rounded  = {1'b0, lane.root} + {{ROOT_W{1'b0}}, round_up};
        s_c      = $signed({1'b0, rounded})
                 + $signed({{(S_W-BIAS_W){lane.side.bias[BIAS_W-1]}}, lane.side.bias});
    end

    // merge into the stored distance; range analysis keeps it inside 24 bits
    always_comb
    begin
        s_wide = {{(DIST_W-S_W){s_reg[S_W-1]}}, s_reg};
        neg_s  = -s_wide;
        old_d  = side_reg.old_distance;
        limit  = shape_is_box(cfg.operation) ? BOX_PAINT_LIMIT : SPHERE_PAINT_LIMIT;
        paint  = (cfg.paint_color != '0) && (s_reg <= limit);
        result_next.new_distance = old_d;
        result_next.new_color    = paint ? cfg.paint_color : side_reg.old_color;
        result_next.painted      = paint;
        unique case (op_t'(cfg.operation)) inside
            OP_SPHERE_REPLACE, OP_BOX_REPLACE:
            begin
                result_next.new_distance = s_wide;
            end
            OP_SPHERE_UNION, OP_BOX_UNION:
            begin
                result_next.new_distance = (s_wide < old_d) ? s_wide : old_d;
            end
            OP_SPHERE_SUBTRACT, OP_BOX_SUBTRACT:
            begin
                result_next.new_distance = (neg_s > old_d) ? neg_s : old_d;
            end
            default:
            begin
                // undefined operation: pass the voxel through untouched
                result_next.new_distance = old_d;
                result_next.new_color    = side_reg.old_color;
                result_next.painted      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg      <= s_c;
            side_reg   <= lane.side;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg      <= in_valid;
            result_valid_reg <= s_valid_reg;
        end
    end

    assign out_valid = result_valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/core/voxel_sdf_stamp_top.sv =====
// Voxel SDF stamp: merges a sphere or box signed distance into a voxel stream.
// Config port: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 operation, 1-3 center x/y/z, 4-6 extent x/y/z,
// 7 paint color. Write registers only while no voxel is in flight.
// Voxel port: voxel_valid/voxel_ready carrying one voxel_t word per voxel.
// Result port: result_valid/result_ready carrying one result_t word per voxel.
// The pipeline holds 25 register stages between the voxel port and result_valid:
// five front stages (offset, magnitude, fold, square, sum), 18 square root cells
// each settling one root bit of the 36-bit sum, one rounding stage and the
// output register.
// Throughput is one voxel per cycle unless stalled; all stages advance together;
// when the receiver holds result_ready low with a result waiting, every stage
// freezes and voxel_ready drops in the same cycle, so nothing is lost.
// Reset clears all valid flags and all configuration registers to zero.
// Depends on vss_pkg, vss_front, vss_root_cell and vss_finish.
module voxel_sdf_stamp_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vss_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 voxel_valid,
    output logic                                 voxel_ready,
    input  vss_pkg::voxel_t                      voxel,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output vss_pkg::result_t                     result
);
    import vss_pkg::*;

    cfg_t  cfg_reg;
    logic  en;
    lane_t lane      [ROOT_STEPS+1];
    logic  lane_valid [ROOT_STEPS+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OPERATION:   cfg_reg.operation   <= cfg_data[OP_W-1:0];
                REG_CENTER_X:    cfg_reg.center_x    <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:    cfg_reg.center_y    <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Z:    cfg_reg.center_z    <= cfg_data[CENTER_W-1:0];
                REG_EXTENT_X:    cfg_reg.extent_x    <= cfg_data[EXTENT_W-1:0];
                REG_EXTENT_Y:    cfg_reg.extent_y    <= cfg_data[EXTENT_W-1:0];
                REG_EXTENT_Z:    cfg_reg.extent_z    <= cfg_data[EXTENT_W-1:0];
                REG_PAINT_COLOR: cfg_reg.paint_color <= cfg_data[COLOR_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline moves whenever the output register is free or being drained
    assign en          = !result_valid || result_ready;
    assign voxel_ready = en;

    vss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (voxel_valid),
        .voxel     (voxel),
        .cfg       (cfg_reg),
        .out_valid (lane_valid[0]),
        .lane      (lane[0])
    );

    // square root chain, one result bit per cell
    for (genvar i = 0; i < ROOT_STEPS; i++)
    begin : g_root
        vss_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (lane_valid[i]),
            .lane_in   (lane[i]),
            .out_valid (lane_valid[i+1]),
            .lane_out  (lane[i+1])
        );
    end

    vss_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lane_valid[ROOT_STEPS]),
        .lane      (lane[ROOT_STEPS]),
        .cfg       (cfg_reg),
        .out_valid (result_valid),
        .result    (result)
    );

endmodule
